// ----- src/eiso_pkg.sv -----
// Shared types, constants and digit helpers for the epoch to ISO 8601 converter.
`timescale 1ns / 1ps

package eiso_pkg;

    // Decoded timestamp handed from the front part to the character serialiser.
    typedef struct packed {
        logic       ok;
        logic [6:0] yy;    // years since 2000
        logic [3:0] mon;
        logic [4:0] day;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } t_stamp;

    localparam logic [31:0] MIN_EPOCH  = 32'd1600000000;
    localparam logic [7:0]  MIN_BUFFER = 8'd21;
    localparam logic [4:0]  LAST_POS   = 5'd19;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Tens digit of a value below 128, by reciprocal multiplication.
    function automatic logic [3:0] f_tens(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] f_units(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(f_tens(v)) * 7'd10;
        return 4'(v - t);
    endfunction

    function automatic logic [7:0] f_char(input logic [3:0] d);
        return CH_ZERO + {4'b0, d};
    endfunction

endpackage

// ----- src/eiso_front.sv -----
// Front part: takes requests, rejects bad ones and splits the epoch into date and time fields.
`timescale 1ns / 1ps

module eiso_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_epoch_seconds,
    input  logic [7:0]           i_buffer_size,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output eiso_pkg::t_stamp     o_rec
);
    import eiso_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DAYS = 4'd1;
    localparam logic [3:0] S_SECS = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_SUB  = 4'd4;
    localparam logic [3:0] S_YOE  = 4'd5;
    localparam logic [3:0] S_DOY  = 4'd6;
    localparam logic [3:0] S_MP   = 4'd7;
    localparam logic [3:0] S_MU   = 4'd8;
    localparam logic [3:0] S_DAY  = 4'd9;
    localparam logic [3:0] S_PUSH = 4'd10;

    logic [3:0]  r_state;
    logic [31:0] r_e;
    logic        r_ok;
    logic [15:0] r_days;
    logic [16:0] r_secs;
    logic [15:0] r_doe;
    logic [5:0]  r_t1;
    logic        r_cent;
    logic [4:0]  r_hh;
    logic [10:0] r_mt;
    logic [5:0]  r_mm;
    logic [5:0]  r_ss;
    logic [15:0] r_n;
    logic [6:0]  r_yoe;
    logic [8:0]  r_doy;
    logic [3:0]  r_mp;
    logic [10:0] r_u;
    logic [4:0]  r_day;
    logic [3:0]  r_mon;
    logic [6:0]  r_yy;

    logic        w_accept;
    logic        w_reject;
    logic [50:0] w_p_days;
    logic [32:0] w_p_ds;
    logic [32:0] w_p_t1;
    logic [34:0] w_p_hh;
    logic [34:0] w_p_mt;
    logic [16:0] w_mt60;
    logic [10:0] w_hh60;
    logic [32:0] w_p_yoe;
    logic [15:0] w_yd;
    logic [15:0] w_doy;
    logic [22:0] w_p_mp;
    logic [22:0] w_p_q;
    logic [8:0]  w_dd;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_reject = (i_buffer_size < MIN_BUFFER) || (i_epoch_seconds < MIN_EPOCH);

    // Every quotient below is a reciprocal product that is exact over its input range.
    assign w_p_days = 51'(r_e[31:7]) * 51'd50903317;
    assign w_p_ds   = 33'(r_days) * 33'd86400;
    assign w_p_t1   = 33'(r_doe) * 33'd91930;
    assign w_p_hh   = 35'(r_secs) * 35'd149131;
    assign w_p_mt   = 35'(r_secs) * 35'd139811;
    assign w_mt60   = 17'(r_mt) * 17'd60;
    assign w_hh60   = 11'(r_hh) * 11'd60;
    assign w_p_yoe  = 33'(r_n) * 33'd91930;
    assign w_yd     = 16'(r_yoe) * 16'd365 + 16'(r_yoe[6:2]) - 16'(r_yoe >= 7'd100);
    assign w_doy    = r_doe - w_yd;
    assign w_p_mp   = (23'(r_doy) * 23'd5 + 23'd2) * 23'd3427;
    assign w_p_q    = 23'(r_u) * 23'd3277;
    assign w_dd     = r_doy - w_p_q[22:14] + 9'd1;

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_q_full;

    always_comb begin
        o_rec     = '0;
        o_rec.ok  = r_ok;
        o_rec.yy  = r_yy;
        o_rec.mon = r_mon;
        o_rec.day = r_day;
        o_rec.hh  = r_hh;
        o_rec.mm  = r_mm;
        o_rec.ss  = r_ss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_reject ? S_PUSH : S_DAYS;
                    end
                end
                S_DAYS:  r_state <= S_SECS;
                S_SECS:  r_state <= S_DIV;
                S_DIV:   r_state <= S_SUB;
                S_SUB:   r_state <= S_YOE;
                S_YOE:   r_state <= S_DOY;
                S_DOY:   r_state <= S_MP;
                S_MP:    r_state <= S_MU;
                S_MU:    r_state <= S_DAY;
                S_DAY:   r_state <= S_PUSH;
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; the epoch is known to be at least 1600000000 here, so
    // the 400-year era is always the one that begins on 2000-03-01.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e  <= i_epoch_seconds;
            r_ok <= !w_reject;
        end
        if (r_state == S_DAYS) begin
            r_days <= w_p_days[50:35];
        end
        if (r_state == S_SECS) begin
            r_secs <= r_e[16:0] - w_p_ds[16:0];
            r_doe  <= r_days - 16'd11017;
        end
        if (r_state == S_DIV) begin
            r_t1   <= w_p_t1[32:27];
            r_cent <= (r_doe >= 16'd36524);
            r_hh   <= w_p_hh[33:29];
            r_mt   <= w_p_mt[33:23];
        end
        if (r_state == S_SUB) begin
            r_n  <= r_doe - 16'(r_t1) + 16'(r_cent);
            r_ss <= 6'(r_secs - w_mt60);
            r_mm <= 6'(r_mt - w_hh60);
        end
        if (r_state == S_YOE) begin
            r_yoe <= w_p_yoe[31:25];
        end
        if (r_state == S_DOY) begin
            r_doy <= w_doy[8:0];
        end
        if (r_state == S_MP) begin
            r_mp <= w_p_mp[22:19];
        end
        if (r_state == S_MU) begin
            r_u <= 11'(r_mp) * 11'd153 + 11'd2;
        end
        if (r_state == S_DAY) begin
            r_day <= w_dd[4:0];
            r_mon <= (r_mp < 4'd10) ? r_mp + 4'd3 : r_mp - 4'd9;
            r_yy  <= r_yoe + 7'(r_mp >= 4'd10);
        end
    end

endmodule

// ----- src/eiso_queue.sv -----
// Short queue of decoded timestamps between the front part and the serialiser.
`timescale 1ns / 1ps

module eiso_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  eiso_pkg::t_stamp     i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output eiso_pkg::t_stamp     o_data
);
    import eiso_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    t_stamp        r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/eiso_back.sv -----
// Back part: emits one character per cycle, twenty per good stamp, one per reject.
`timescale 1ns / 1ps

module eiso_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  eiso_pkg::t_stamp     i_q_data,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [7:0]           o_text_char,
    output logic                 o_last_char,
    output logic                 o_ok
);
    import eiso_pkg::*;

    t_stamp     r_rec;
    logic       r_act;
    logic [4:0] r_idx;
    logic       r_strobe;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_ok;

    logic       w_last;
    logic       w_load;
    logic [6:0] w_yy2;
    logic [7:0] w_char;

    assign w_last = r_act && (!r_rec.ok || (r_idx == LAST_POS));
    assign w_load = i_q_valid && (!r_act || w_last);
    assign o_pop  = w_load;
    assign w_yy2  = (r_rec.yy >= 7'd100) ? r_rec.yy - 7'd100 : r_rec.yy;

    always_comb begin
        unique case (r_idx)
            5'd0:    w_char = CH_TWO;
            5'd1:    w_char = f_char(4'(r_rec.yy >= 7'd100));
            5'd2:    w_char = f_char(f_tens(w_yy2));
            5'd3:    w_char = f_char(f_units(w_yy2));
            5'd5:    w_char = f_char(f_tens(7'(r_rec.mon)));
            5'd6:    w_char = f_char(f_units(7'(r_rec.mon)));
            5'd8:    w_char = f_char(f_tens(7'(r_rec.day)));
            5'd9:    w_char = f_char(f_units(7'(r_rec.day)));
            5'd10:   w_char = CH_T;
            5'd11:   w_char = f_char(f_tens(7'(r_rec.hh)));
            5'd12:   w_char = f_char(f_units(7'(r_rec.hh)));
            5'd14:   w_char = f_char(f_tens(7'(r_rec.mm)));
            5'd15:   w_char = f_char(f_units(7'(r_rec.mm)));
            5'd17:   w_char = f_char(f_tens(7'(r_rec.ss)));
            5'd18:   w_char = f_char(f_units(7'(r_rec.ss)));
            5'd4,
            5'd7:    w_char = CH_DASH;
            5'd13,
            5'd16:   w_char = CH_COLON;
            default: w_char = CH_Z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rec <= i_q_data;
        end
        r_char <= r_rec.ok ? w_char : CH_NUL;
        r_last <= w_last;
        r_ok   <= r_rec.ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act;
            if (w_load) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (w_last) begin
                r_act <= 1'b0;
            end else if (r_act) begin
                r_idx <= r_idx + 5'd1;
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    assign o_ok        = r_ok;

endmodule

// ----- src/epoch_to_iso8601_utc.sv -----
// Top level of the Unix epoch to ISO 8601 UTC text converter.
`timescale 1ns / 1ps

// A request is taken at a rising edge where start is high and busy is low; it
// carries a 32-bit count of seconds since 1970-01-01 00:00:00 UTC. The block
// answers with the text YYYY-MM-DDTHH:MM:SSZ, one ASCII character per cycle on
// o_text_char, each shown for one cycle under o_strobe, the final one flagged
// by o_last_char. An epoch before 1600000000, or a buffer size below 21, gives
// one character of zero with o_ok low and o_last_char high instead.
// The buffer size is written through i_cfg_we and i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. A good
// request passes through the front part, a ten-step sequencer of reciprocal
// multiplications, then the queue and the back part, which registers each
// character; a rejected one goes straight to the push step. The front part
// holds busy until its record is pushed, which waits while the queue is full.
// Sustained throughput of good requests is set by the back part, which sends
// one character per cycle. The queue between them lets the front work on the
// next request while the back is still sending. The receiver cannot stall:
// characters leave at the full rate. Reset clears the sequencer, the queue
// and the serialiser, and sets the buffer size to 21.
module epoch_to_iso8601_utc #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic        o_ok
);
    import eiso_pkg::*;

    logic [7:0] r_buffer_size;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_q_valid;
    t_stamp     w_front_rec;
    t_stamp     w_q_rec;

    // Destination buffer size; only its comparison with 21 matters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= MIN_BUFFER;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    eiso_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_epoch_seconds (i_epoch_seconds),
        .i_buffer_size   (r_buffer_size),
        .i_q_full        (w_full),
        .o_busy          (busy),
        .o_push          (w_push),
        .o_rec           (w_front_rec)
    );

    eiso_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_rec)
    );

    eiso_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_rec),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char),
        .o_ok        (o_ok)
    );

    // A taken request always keeps the front part occupied in the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("front part did not hold busy after a request");

    // The front part never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    // A good timestamp is sent without gaps until its final character.
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_ok && !o_last_char |=> o_strobe && o_ok)
        else $error("gap inside a timestamp");

    // A rejected request gives a single final zero character.
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_ok |-> o_last_char && (o_text_char == CH_NUL))
        else $error("malformed rejection result");

endmodule

// ----- bench/eiso_text_checker.sv -----
// Watches the request and character channels of the epoch converter and checks the text.
`timescale 1ns / 1ps

module eiso_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_strobe,
    input  logic [7:0]  i_text_char,
    input  logic        i_last_char,
    input  logic        i_ok,
    output int          o_fail_count,
    output int          o_pending
);
    import eiso_pkg::*;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
        logic       ok;
    } t_char_result;

    t_char_result expected_chars[$];
    logic [7:0]   buffer_size;
    int           fault_count;

    function automatic bit is_leap_year(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    // Walks whole years and then whole months from 1970 to find the calendar date.
    function automatic void queue_timestamp(input logic [31:0] epoch, input logic [7:0] size);
        int unsigned  day_count;
        int unsigned  sec_of_day;
        int unsigned  year;
        int unsigned  month;
        int unsigned  month_len;
        string        text;
        t_char_result item;
        if (size < MIN_BUFFER || epoch < MIN_EPOCH) begin
            item.text_char = CH_NUL;
            item.last_char = 1'b1;
            item.ok        = 1'b0;
            expected_chars.push_back(item);
            return;
        end
        day_count  = epoch / 86400;
        sec_of_day = epoch % 86400;
        year = 1970;
        while (day_count >= (is_leap_year(year) ? 366 : 365)) begin
            day_count -= is_leap_year(year) ? 366 : 365;
            year++;
        end
        for (month = 1; month <= 12; month++) begin
            case (month)
                2: begin
                    month_len = is_leap_year(year) ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    month_len = 30;
                end
                default: begin
                    month_len = 31;
                end
            endcase
            if (day_count < month_len) break;
            day_count -= month_len;
        end
        text = $sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", year, month, day_count + 1,
                         sec_of_day / 3600, (sec_of_day / 60) % 60, sec_of_day % 60);
        for (int k = 0; k < 20; k++) begin
            item.text_char = text.getc(k);
            item.last_char = (k == 19);
            item.ok        = 1'b1;
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_result want;
        if (!i_rst_n) begin
            buffer_size = MIN_BUFFER;
            expected_chars.delete();
        end else begin
            // Compare before queueing, so that a stray strobe never meets a fresh request.
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected character %h last %b ok %b at %0t",
                                 i_text_char, i_last_char, i_ok, $realtime);
                end else begin
                    want = expected_chars.pop_front();
                    if (want.text_char !== i_text_char || want.last_char !== i_last_char ||
                        want.ok !== i_ok) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"mismatch at %0t: expected char %h last %b ok %b,",
                                      " got %h %b %b"},
                                     $realtime, want.text_char, want.last_char, want.ok,
                                     i_text_char, i_last_char, i_ok);
                    end
                end
            end
            if (i_cfg_we) buffer_size = i_cfg_data;
            if (i_start && !i_busy) queue_timestamp(i_epoch_seconds, buffer_size);
        end
        o_pending    = expected_chars.size();
        o_fail_count = fault_count;
    end

    initial begin
        fault_count  = 0;
        buffer_size  = MIN_BUFFER;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the testbench for the epoch to ISO 8601 converter: clock, reset, requests and verdict.
`timescale 1ns / 1ps

// The top only makes stimulus. The checker beside the block watches every
// accepted request and every character strobe, predicts the text on its own
// and hands back a count of failures and of characters still awaited.
//
// The run goes through several buffer sizes: the reset value first, then the
// largest, zero, one below the threshold, the threshold itself and random
// values. The buffer size is only written once every awaited character has
// arrived and the block has dropped busy.
module tb_top;
    import eiso_pkg::*;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_cfg_we        = 1'b0;
    logic [7:0]  i_cfg_data      = '0;
    logic        o_strobe;
    logic [7:0]  o_text_char;
    logic        o_last_char;
    logic        o_ok;

    int fail_count;
    int pending;
    int burst_left = 0;

    // Directed requests: the epoch extremes, both sides of the lower limit,
    // year and leap day edges, and the end of February in the year 2100, which
    // is not a leap year.
    localparam int N_DIRECTED = 22;
    localparam logic [31:0] DIRECTED_EPOCHS [N_DIRECTED] = '{
        32'd0,          32'd1,          32'd1599999999, 32'd1600000000,
        32'd1600000001, 32'd1609459199, 32'd1609459200, 32'd1709164799,
        32'd1709164800, 32'd1709251200, 32'd1735689599, 32'd1735689600,
        32'h7FFFFFFF,   32'h80000000,   32'hAAAAAAAA,   32'h55555555,
        32'd4102444799, 32'd4102444800, 32'd4107542399, 32'd4107542400,
        32'hFFFFFFFE,   32'hFFFFFFFF
    };

    epoch_to_iso8601_utc i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_text_char     (o_text_char),
        .o_last_char     (o_last_char),
        .o_ok            (o_ok)
    );

    eiso_text_checker u_text_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_text_char     (o_text_char),
        .i_last_char     (o_last_char),
        .i_ok            (o_ok),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly epochs that convert, with some near midnight, some anywhere in
    // the 32-bit range, and some that must be rejected as too early.
    function automatic logic [31:0] pick_epoch();
        int unsigned    pick;
        longint unsigned stamp;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return $urandom_range(32'hFFFFFFFF, MIN_EPOCH);
        end else if (pick < 75) begin
            // A random midnight give or take up to two minutes, where the date rolls over.
            stamp = longint'($urandom_range(49710, 18519)) * 86400;
            case ($urandom_range(0, 3))
                0: stamp = stamp - 1;
                1: stamp = stamp + $urandom_range(0, 2);
                2: stamp = stamp + 86399;
                default: stamp = stamp - $urandom_range(1, 120);
            endcase
            if (stamp > 64'hFFFFFFFF) return 32'hFFFFFFFF - $urandom_range(0, 100);
            return stamp[31:0];
        end else if (pick < 85) begin
            return $urandom();
        end else if (pick < 93) begin
            return $urandom_range(MIN_EPOCH - 1, 0);
        end else begin
            return MIN_EPOCH + $urandom_range(0, 200) - 100;
        end
    endfunction

    // Holds start high from the current falling edge until a rising edge takes
    // the request, and returns at the next falling edge with start still high.
    task automatic send_epoch(input logic [31:0] epoch);
        start           <= 1'b1;
        i_epoch_seconds <= epoch;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Lowers start and waits until every awaited character has come and the
    // block is no longer busy.
    task automatic drain_requests();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
    endtask

    // After each request the sender either waits for the block to empty, runs
    // in a burst with no gap, or idles for a random number of cycles.
    task automatic pause_after_request();
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            drain_requests();
        end else begin
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 16);
                if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(5, 20);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // One phase: empty the block, optionally set the buffer size, then send
    // random requests.
    task automatic run_phase(input bit do_write, input logic [7:0] size, input int item_total);
        drain_requests();
        if (do_write) begin
            i_cfg_we   <= 1'b1;
            i_cfg_data <= size;
            @(negedge i_clk);
            i_cfg_we   <= 1'b0;
        end
        for (int n = 0; n < item_total; n++) begin
            send_epoch(pick_epoch());
            pause_after_request();
        end
    endtask

    initial begin
        // Synchronous reset, applied once at the start and never again.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests under the reset buffer size.
        foreach (DIRECTED_EPOCHS[k]) begin
            send_epoch(DIRECTED_EPOCHS[k]);
            pause_after_request();
        end

        run_phase(1'b0, MIN_BUFFER, 30);
        run_phase(1'b1, 8'd255, 130);
        run_phase(1'b1, 8'd0, 15);
        run_phase(1'b1, MIN_BUFFER - 8'd1, 15);
        run_phase(1'b1, MIN_BUFFER, 110);
        run_phase(1'b1, 8'($urandom_range(254, 22)), 100);
        run_phase(1'b1, 8'($urandom_range(255, 0)), 60);
        run_phase(1'b1, MIN_BUFFER, 40);

        // Wait for the last characters, then leave room for any stray output.
        drain_requests();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #(5_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- epoch_to_iso8601_utc.f -----
src/eiso_pkg.sv
src/eiso_front.sv
src/eiso_queue.sv
src/eiso_back.sv
src/epoch_to_iso8601_utc.sv
bench/eiso_text_checker.sv
bench/tb_top.sv
